// ===== rtl/json_string_body_decoder_assert.svh =====
// Assertion macros for the string decoder.
`ifndef JSON_STRING_BODY_DECODER_ASSERT_SVH
`define JSON_STRING_BODY_DECODER_ASSERT_SVH
`ifndef SYNTH
`define JSD_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("string decoder check failed");
`define JSD_NEVER(lbl, cond) `JSD_ASSERT(lbl, !(cond))
`else
`define JSD_ASSERT(lbl, prop)
`define JSD_NEVER(lbl, cond)
`endif
`endif

// ===== rtl/jsd_pkg.sv =====
package jsd_pkg;

	typedef enum logic [1:0] {
		K_CHAR  = 2'd0,
		K_CLOSE = 2'd1,
		K_ERR   = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		E_NONE      = 3'd0,
		E_BAD_LEAD  = 3'd1,
		E_UNTERM    = 3'd2,
		E_BAD_ESC   = 3'd3,
		E_BAD_HEX   = 3'd4,
		E_ABOVE_MAX = 3'd5
	} err_t;

	typedef enum logic [2:0] {
		M_IDLE    = 3'd0,
		M_STR     = 3'd1,
		M_UTF8    = 3'd2,
		M_ESC     = 3'd3,
		M_HEX     = 3'd4,
		M_PAIR_BS = 3'd5,
		M_PAIR_U  = 3'd6,
		M_HEX2    = 3'd7
	} mode_t;

	typedef enum logic [1:0] {
		T_NONE  = 2'd0,
		T_CLOSE = 2'd1,
		T_FAIL  = 2'd2
	} tail_t;

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_BS     = 8'h08;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_TAB    = 8'h09;

	localparam logic [15:0] HI_SUR_FIRST = 16'hD800;
	localparam logic [15:0] HI_SUR_LAST  = 16'hDBFF;
	localparam logic [15:0] LO_SUR_FIRST = 16'hDC00;
	localparam logic [15:0] LO_SUR_LAST  = 16'hDFFF;
	localparam logic [20:0] SUPP_BASE    = 21'h010000;
	localparam logic [20:0] MAX_CP       = 21'h10FFFF;

	typedef struct packed {
		mode_t       mode;
		logic [15:0] hex_acc;
		logic [1:0]  hex_seen;
		logic [20:0] u_acc;
		logic [1:0]  u_rem;
		logic [15:0] held;
		logic [20:0] mx;
	} st_t;

	localparam st_t ST_RESET = '{
		mode: M_IDLE, hex_acc: 16'd0, hex_seen: 2'd0, u_acc: 21'd0,
		u_rem: 2'd0, held: 16'd0, mx: 21'd0
	};

	typedef struct packed {
		mode_t       mode;
		logic        set_u;
		logic [20:0] u_acc;
		logic [1:0]  u_rem;
		logic        set_hex;
		logic        emit;
		logic [20:0] cp;
		tail_t       tail;
		err_t        err;
	} act_t;

	typedef struct packed {
		kind_t       kind;
		logic [20:0] cp;
		err_t        err;
		logic [15:0] cnt;
		logic [20:0] mx;
	} res_t;

	typedef struct packed {
		logic [1:0]       n;
		res_t [2:0]       r;
	} bundle_t;

	// bit 4 set: not a hex digit
	function automatic logic [4:0] hex_val(input logic [7:0] b);
		logic [4:0] v;
		case (b) inside
			[8'h30:8'h39]:                v = {1'b0, b[3:0]};
			[8'h41:8'h46], [8'h61:8'h66]: v = {1'b0, 4'(b[3:0] + 4'd9)};
			default:                      v = 5'h10;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/jsd_step.sv =====
module jsd_step #(
	parameter int COUNT_BITS = 16
) (
	input  jsd_pkg::st_t            st,
	input  logic [COUNT_BITS-1:0]   cnt,
	input  logic [7:0]              byte_in,
	input  logic                    buffer_last,
	output jsd_pkg::st_t            nst,
	output logic [COUNT_BITS-1:0]   ncnt,
	output jsd_pkg::bundle_t        bundle
);

	function automatic jsd_pkg::act_t do_plain(input logic [7:0] b);
		jsd_pkg::act_t a;
		a = '0;
		a.mode = jsd_pkg::M_STR;
		if (b == jsd_pkg::CH_BSLASH) begin
			a.mode = jsd_pkg::M_ESC;
		end else if (b == jsd_pkg::CH_QUOTE) begin
			a.tail = jsd_pkg::T_CLOSE;
			a.mode = jsd_pkg::M_IDLE;
		end else if (!b[7]) begin
			a.emit = 1'b1;
			a.cp = {13'd0, b};
		end else if (b[7:5] == 3'b110) begin
			a.set_u = 1'b1;
			a.u_acc = {16'd0, b[4:0]};
			a.u_rem = 2'd1;
			a.mode = jsd_pkg::M_UTF8;
		end else if (b[7:4] == 4'b1110) begin
			a.set_u = 1'b1;
			a.u_acc = {17'd0, b[3:0]};
			a.u_rem = 2'd2;
			a.mode = jsd_pkg::M_UTF8;
		end else if (b[7:3] == 5'b11110) begin
			a.set_u = 1'b1;
			a.u_acc = {18'd0, b[2:0]};
			a.u_rem = 2'd3;
			a.mode = jsd_pkg::M_UTF8;
		end else begin
			a.tail = jsd_pkg::T_FAIL;
			a.err = jsd_pkg::E_BAD_LEAD;
			a.mode = jsd_pkg::M_IDLE;
		end
		return a;
	endfunction

	function automatic jsd_pkg::act_t do_esc(input logic [7:0] b);
		jsd_pkg::act_t a;
		a = '0;
		a.mode = jsd_pkg::M_STR;
		a.emit = 1'b1;
		case (b)
			jsd_pkg::CH_BSLASH: a.cp = {13'd0, jsd_pkg::CH_BSLASH};
			jsd_pkg::CH_QUOTE:  a.cp = {13'd0, jsd_pkg::CH_QUOTE};
			jsd_pkg::CH_SLASH:  a.cp = {13'd0, jsd_pkg::CH_SLASH};
			jsd_pkg::CH_B:      a.cp = {13'd0, jsd_pkg::CH_BS};
			jsd_pkg::CH_F:      a.cp = {13'd0, jsd_pkg::CH_FF};
			jsd_pkg::CH_N:      a.cp = {13'd0, jsd_pkg::CH_LF};
			jsd_pkg::CH_R:      a.cp = {13'd0, jsd_pkg::CH_CR};
			jsd_pkg::CH_T:      a.cp = {13'd0, jsd_pkg::CH_TAB};
			jsd_pkg::CH_U: begin
				a.emit = 1'b0;
				a.set_hex = 1'b1;
				a.mode = jsd_pkg::M_HEX;
			end
			default: begin
				a.emit = 1'b0;
				a.tail = jsd_pkg::T_FAIL;
				a.err = jsd_pkg::E_BAD_ESC;
				a.mode = jsd_pkg::M_IDLE;
			end
		endcase
		return a;
	endfunction

	function automatic logic [15:0] lo16(input logic [COUNT_BITS-1:0] c);
		logic [31:0] w;
		w = 32'(c);
		return w[15:0];
	endfunction

	jsd_pkg::act_t          a;
	logic                   use_a;
	logic [1:0]             e_n;
	logic [20:0]            e_cp [2];
	jsd_pkg::tail_t         tail;
	jsd_pkg::err_t          terr;
	logic [4:0]             d;
	logic [15:0]            hacc;
	logic [1:0]             rem;
	logic [COUNT_BITS-1:0]  c;
	logic [20:0]            m;

	always_comb begin
		nst = st;
		c = cnt;
		m = st.mx;
		a = '0;
		use_a = 1'b0;
		e_n = 2'd0;
		e_cp[0] = '0;
		e_cp[1] = '0;
		tail = jsd_pkg::T_NONE;
		terr = jsd_pkg::E_NONE;
		d = jsd_pkg::hex_val(byte_in);
		hacc = {st.hex_acc[11:0], d[3:0]};
		rem = st.u_rem - {1'b0, (st.u_rem != 2'd0)};
		bundle = '0;

		case (st.mode)
			jsd_pkg::M_IDLE: begin
				nst = jsd_pkg::ST_RESET;
				nst.mode = jsd_pkg::M_STR;
				c = '0;
				m = '0;
			end
			jsd_pkg::M_STR: begin
				a = do_plain(byte_in);
				use_a = 1'b1;
			end
			jsd_pkg::M_UTF8: begin
				nst.u_acc = {st.u_acc[14:0], byte_in[5:0]};
				nst.u_rem = rem;
				if (rem == 2'd0) begin
					e_cp[0] = nst.u_acc;
					e_n = 2'd1;
					nst.mode = jsd_pkg::M_STR;
				end
			end
			jsd_pkg::M_ESC: begin
				a = do_esc(byte_in);
				use_a = 1'b1;
			end
			jsd_pkg::M_HEX, jsd_pkg::M_HEX2: begin
				if (d[4]) begin
					tail = jsd_pkg::T_FAIL;
					terr = jsd_pkg::E_BAD_HEX;
					nst.mode = jsd_pkg::M_IDLE;
				end else begin
					nst.hex_acc = hacc;
					if (st.hex_seen != 2'd3) begin
						nst.hex_seen = st.hex_seen + 2'd1;
					end else begin
						nst.hex_seen = 2'd0;
						nst.mode = jsd_pkg::M_STR;
						if (st.mode == jsd_pkg::M_HEX) begin
							if (hacc inside {[jsd_pkg::HI_SUR_FIRST:jsd_pkg::HI_SUR_LAST]}) begin
								nst.held = hacc;
								nst.mode = jsd_pkg::M_PAIR_BS;
							end else begin
								e_cp[0] = {5'd0, hacc};
								e_n = 2'd1;
							end
						end else begin
							if (hacc inside {[jsd_pkg::LO_SUR_FIRST:jsd_pkg::LO_SUR_LAST]}) begin
								e_cp[0] = jsd_pkg::SUPP_BASE + {1'b0, st.held[9:0], hacc[9:0]};
								e_n = 2'd1;
							end else begin
								e_cp[0] = {5'd0, st.held};
								e_cp[1] = {5'd0, hacc};
								e_n = 2'd2;
							end
							nst.held = '0;
						end
					end
				end
			end
			jsd_pkg::M_PAIR_BS: begin
				if (byte_in == jsd_pkg::CH_BSLASH) begin
					nst.mode = jsd_pkg::M_PAIR_U;
				end else begin
					e_cp[0] = {5'd0, st.held};
					e_n = 2'd1;
					nst.held = '0;
					a = do_plain(byte_in);
					use_a = 1'b1;
				end
			end
			jsd_pkg::M_PAIR_U: begin
				if (byte_in == jsd_pkg::CH_U) begin
					nst.hex_acc = '0;
					nst.hex_seen = '0;
					nst.mode = jsd_pkg::M_HEX2;
				end else begin
					e_cp[0] = {5'd0, st.held};
					e_n = 2'd1;
					nst.held = '0;
					a = do_esc(byte_in);
					use_a = 1'b1;
				end
			end
			default: begin
				nst.mode = jsd_pkg::M_IDLE;
			end
		endcase

		if (use_a) begin
			nst.mode = a.mode;
			if (a.set_u) begin
				nst.u_acc = a.u_acc;
				nst.u_rem = a.u_rem;
			end
			if (a.set_hex) begin
				nst.hex_acc = '0;
				nst.hex_seen = '0;
			end
			if (a.emit) begin
				e_cp[e_n[0]] = a.cp;
				e_n = e_n + 2'd1;
			end
			if (a.tail != jsd_pkg::T_NONE) begin
				tail = a.tail;
				terr = a.err;
			end
		end

		if (tail == jsd_pkg::T_NONE && buffer_last && nst.mode != jsd_pkg::M_IDLE) begin
			tail = jsd_pkg::T_FAIL;
			terr = jsd_pkg::E_UNTERM;
			nst.mode = jsd_pkg::M_IDLE;
		end

		for (int i = 0; i < 2; i++) begin
			if (2'(i) < e_n) begin
				if (c != '1)
					c = c + COUNT_BITS'(1);
				if (e_cp[i] > m)
					m = e_cp[i];
				bundle.r[i] = '{kind: jsd_pkg::K_CHAR, cp: e_cp[i], err: jsd_pkg::E_NONE,
					cnt: lo16(c), mx: m};
			end
		end

		if (tail == jsd_pkg::T_CLOSE) begin
			if (m > jsd_pkg::MAX_CP)
				bundle.r[e_n] = '{kind: jsd_pkg::K_ERR, cp: 21'd0,
					err: jsd_pkg::E_ABOVE_MAX, cnt: lo16(c), mx: m};
			else
				bundle.r[e_n] = '{kind: jsd_pkg::K_CLOSE, cp: 21'd0,
					err: jsd_pkg::E_NONE, cnt: lo16(c), mx: m};
		end else if (tail == jsd_pkg::T_FAIL) begin
			bundle.r[e_n] = '{kind: jsd_pkg::K_ERR, cp: 21'd0, err: terr,
				cnt: lo16(c), mx: m};
		end

		bundle.n = e_n + {1'b0, (tail != jsd_pkg::T_NONE)};
		nst.mx = m;
		ncnt = c;
	end

endmodule

// ===== rtl/jsd_out.sv =====
`include "json_string_body_decoder_assert.svh"

module jsd_out (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  jsd_pkg::bundle_t     bundle_in,
	output logic                 free,
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic [1:0]           kind,
	output logic [20:0]          code_point,
	output logic [2:0]           error_code,
	output logic [15:0]          char_count,
	output logic [20:0]          max_code_point,
	output logic                 last
);

	jsd_pkg::bundle_t  bun_q;
	logic [1:0]        n_q;
	logic [1:0]        idx_q;
	jsd_pkg::res_t     cur;
	logic              take;

	assign result_valid = (idx_q != n_q);
	assign take = result_valid && !result_stall;
	assign last = (idx_q == n_q - 2'd1);
	assign free = !result_valid || (take && last);

	always_comb begin
		case (idx_q)
			2'd0:    cur = bun_q.r[0];
			2'd1:    cur = bun_q.r[1];
			default: cur = bun_q.r[2];
		endcase
	end

	assign kind = cur.kind;
	assign code_point = cur.cp;
	assign error_code = cur.err;
	assign char_count = cur.cnt;
	assign max_code_point = cur.mx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= 2'd0;
			idx_q <= 2'd0;
		end else if (load) begin
			n_q <= bundle_in.n;
			idx_q <= 2'd0;
		end else if (take) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			bun_q <= bundle_in;
	end

	`JSD_NEVER(idx_past_count, idx_q > n_q)
	`JSD_ASSERT(mid_beat_next, (take && !last && !load) |=> (result_valid && idx_q == $past(idx_q) + 2'd1))
	`JSD_ASSERT(final_beat_frees, (take && last) |-> free)

endmodule

// ===== rtl/json_string_body_decoder.sv =====
// A byte is registered in byte_s1; its results are then registered in jsd_out's bun_q.
// Throughput: one byte per cycle if each byte gives at most one result and no stall;
// a byte with more results (up to 3) holds the input while the single result register
// drains one beat per unstalled cycle. Bytes with no result never hold the input.
// Reset: arst_n clears the decoder to idle and empties both registers; no clearing pass.
`include "json_string_body_decoder_assert.svh"

module json_string_body_decoder #(
	parameter int COUNT_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         byte_valid,
	output logic         byte_stall,
	input  logic [7:0]   byte_in,
	input  logic         buffer_last,
	output logic         result_valid,
	input  logic         result_stall,
	output logic [1:0]   kind,
	output logic [20:0]  code_point,
	output logic [2:0]   error_code,
	output logic [15:0]  char_count,
	output logic [20:0]  max_code_point,
	output logic         last
);

	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   last_s1;
	jsd_pkg::st_t           st_q;
	jsd_pkg::st_t           nst;
	logic [COUNT_BITS-1:0]  cnt_q;
	logic [COUNT_BITS-1:0]  ncnt;
	jsd_pkg::bundle_t       bundle;
	logic                   free;
	logic                   advance;

	assign advance = valid_s1 && free;
	assign byte_stall = valid_s1 && !free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			byte_s1 <= byte_in;
			last_s1 <= buffer_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= jsd_pkg::ST_RESET;
			cnt_q <= '0;
		end else if (advance) begin
			st_q <= nst;
			cnt_q <= ncnt;
		end
	end

	jsd_step #(
		.COUNT_BITS(COUNT_BITS)
	) u_step (
		.st(st_q),
		.cnt(cnt_q),
		.byte_in(byte_s1),
		.buffer_last(last_s1),
		.nst(nst),
		.ncnt(ncnt),
		.bundle(bundle)
	);

	jsd_out u_out (
		.clk(clk),
		.arst_n(arst_n),
		.load(advance),
		.bundle_in(bundle),
		.free(free),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.kind(kind),
		.code_point(code_point),
		.error_code(error_code),
		.char_count(char_count),
		.max_code_point(max_code_point),
		.last(last)
	);

	`JSD_ASSERT(end_of_buffer_idles, (advance && last_s1) |=> (st_q.mode == jsd_pkg::M_IDLE))
	`JSD_ASSERT(held_byte_stays, (valid_s1 && !advance) |=> (valid_s1 && $stable(byte_s1)))

endmodule
